[sv/sdk_pkg.sv]
// sidechain ducker package: item types, register codes, constants and the exp2 root table
// no dependencies
`default_nettype none

package sdk_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS = 16;
  localparam int THR_BITS = 23;
  localparam int RATIO_BITS = 15;
  localparam int LOG_FRAC = 16;
  localparam int LOG_INT_BITS = 5;
  localparam int LOG_BITS = LOG_INT_BITS + LOG_FRAC;
  localparam int NORM_BITS = 31;
  localparam int MANT_BITS = 32;
  localparam int GAIN_BITS = 39;
  localparam int PROD_BITS = SAMPLE_BITS + MANT_BITS;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 23;
  localparam int SDK_QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RATIO = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE = 2'd3;

  localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 23'd838861;
  localparam logic [RATIO_BITS-1:0] RATIO_RESET = 15'd1024;
  localparam logic [COEF_BITS-1:0] ATTACK_RESET = 16'd64880;
  localparam logic [COEF_BITS-1:0] RELEASE_RESET = 16'd65500;
  localparam logic [RATIO_BITS-1:0] RATIO_UNITY = 15'd256;
  localparam logic [MANT_BITS-1:0] MANT_ONE = 32'h4000_0000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] main_sample;
    logic signed [SAMPLE_BITS-1:0] side_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic ducking;
    logic clipped;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] main_sample;
    logic duck;
    logic [SAMPLE_BITS-1:0] env;
  } q_item_t;

  typedef struct packed {
    logic [THR_BITS-1:0] thr;
    logic [RATIO_BITS-1:0] ratio;
    logic [COEF_BITS-1:0] attack;
    logic [COEF_BITS-1:0] release_c;
  } cfg_t;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_SUM, F_PUSH} f_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_LOG, B_GAIN, B_EXP, B_PROD, B_ROUND, B_DONE
  } b_state_t;

  typedef logic [MANT_BITS-1:0] root_arr_t [LOG_FRAC+1];

  function automatic root_arr_t build_roots();
    root_arr_t t;
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    c = 64'd1 << 31;
    t[0] = c[MANT_BITS-1:0];
    for (int k = 1; k <= LOG_FRAC; k++) begin
      v = c << 30;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      c = r;
      t[k] = c[MANT_BITS-1:0];
    end
    return t;
  endfunction

  localparam root_arr_t ROOT_TAB = build_roots();

endpackage

`default_nettype wire

[sv/sdk_front.sv]
// front end: takes a transaction, finds the sidechain level and updates the envelope
// depends on sdk_pkg
`default_nettype none

module sdk_front import sdk_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire in_item_t in_data,
  input  wire cfg_t cfg,
  input  wire logic [THR_BITS-1:0] thr_eff,
  output logic q_push,
  input  wire logic q_ready,
  output q_item_t q_data
);

  f_state_t state, state_next;
  logic signed [SAMPLE_BITS-1:0] main_q;
  logic [SAMPLE_BITS-1:0] mag_q;
  logic duck_q;
  logic [SAMPLE_BITS-1:0] envelope;
  logic [SAMPLE_BITS+COEF_BITS-1:0] p1;
  logic [SAMPLE_BITS+COEF_BITS:0] p2;
  logic [SAMPLE_BITS+COEF_BITS+1:0] sum;
  logic [SAMPLE_BITS-1:0] mag;
  logic [COEF_BITS:0] one_minus_a;

  always_comb begin
    mag = in_data.side_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_data.side_sample)
                                              : in_data.side_sample;
    one_minus_a = (17'd1 << COEF_BITS) - {1'b0, cfg.attack};
    sum = {2'b0, p1} + {1'b0, p2}
        + (duck_q ? (42'd1 << (COEF_BITS - 1)) : 42'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    q_push = 1'b0;
    case (state)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = F_MUL;
      end
      F_MUL: state_next = F_SUM;
      F_SUM: state_next = F_PUSH;
      F_PUSH: begin
        q_push = 1'b1;
        if (q_ready) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      envelope <= '0;
    end else if (state == F_SUM) begin
      envelope <= duck_q ? sum[SAMPLE_BITS+COEF_BITS-1:COEF_BITS]
                         : p1[SAMPLE_BITS+COEF_BITS-1:COEF_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      main_q <= in_data.main_sample;
      mag_q <= mag;
      duck_q <= mag > {1'b0, thr_eff};
    end
    if (state == F_MUL) begin
      p1 <= (duck_q ? cfg.attack : cfg.release_c) * envelope;
      p2 <= duck_q ? one_minus_a * mag_q : '0;
    end
  end

  assign q_data.main_sample = main_q;
  assign q_data.duck = duck_q;
  assign q_data.env = envelope;

`ifndef SYNTHESIS
  a_env_bound: assert property (@(posedge clk) disable iff (rst)
    envelope <= (24'd1 << (SAMPLE_BITS - 1)))
    else $error("envelope above full scale");
`endif

endmodule

`default_nettype wire

[sv/sdk_fifo.sv]
// short queue of classified items between the front end and the gain engine
// depends on sdk_pkg
`default_nettype none

module sdk_fifo import sdk_pkg::*; #(
  parameter int DEPTH = SDK_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic push_ready,
  input  wire q_item_t push_data,
  input  wire logic pop,
  output logic not_empty,
  output q_item_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push, do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign not_empty = count != '0;
  assign do_push = push && push_ready;
  assign do_pop = pop && not_empty;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

[sv/sdk_back.sv]
// gain engine: log2 of envelope and threshold, gain power via exp2 roots, scale and saturate
// depends on sdk_pkg
`default_nettype none

module sdk_back import sdk_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire q_item_t q_data,
  output logic q_pop,
  input  wire logic [THR_BITS-1:0] thr_eff,
  input  wire logic [RATIO_BITS-1:0] ratio,
  output logic out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  b_state_t state, state_next;
  q_item_t item;
  logic [3:0] cnt;
  logic [NORM_BITS-1:0] me, mt;
  logic [LOG_FRAC-1:0] fe, ft;
  logic [LOG_INT_BITS-1:0] pe, pt;
  logic signed [GAIN_BITS-1:0] g_q;
  logic [MANT_BITS-1:0] mant;
  logic [PROD_BITS-1:0] prod_q;
  logic [SAMPLE_BITS-1:0] res_q;
  logic clip_q;
  logic write_out;

  logic [SAMPLE_BITS-1:0] env_eff;
  logic [LOG_INT_BITS-1:0] pe_init, pt_init;
  logic [2*NORM_BITS-1:0] sq_e, sq_t;
  logic [NORM_BITS:0] qe, qt;
  logic signed [LOG_BITS:0] d;
  logic signed [RATIO_BITS+1:0] slope;
  logic [RATIO_BITS-1:0] ratio_eff;
  logic [LOG_FRAC-1:0] f;
  logic [2*MANT_BITS-1:0] mprod;
  logic [SAMPLE_BITS-1:0] smag;
  logic signed [GAIN_BITS-25:0] n;
  logic signed [15:0] sh_full;
  logic [5:0] sh;
  logic [63:0] prod64, res, limit;
  logic neg, clip;

  function automatic logic [LOG_INT_BITS-1:0] msb_index(input logic [SAMPLE_BITS-1:0] x);
    logic [LOG_INT_BITS-1:0] p;
    p = '0;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      if (x[i]) p = LOG_INT_BITS'(i);
    end
    return p;
  endfunction

  function automatic logic [NORM_BITS-1:0] normalize(input logic [SAMPLE_BITS-1:0] x,
                                                      input logic [LOG_INT_BITS-1:0] p);
    logic [NORM_BITS-1:0] w;
    w = NORM_BITS'(x);
    return w << (LOG_INT_BITS'(30) - p);
  endfunction

  always_comb begin
    env_eff = (q_data.env == '0) ? SAMPLE_BITS'(1) : q_data.env;
    pe_init = msb_index(env_eff);
    pt_init = msb_index({1'b0, thr_eff});
    sq_e = me * me;
    sq_t = mt * mt;
    qe = sq_e[2*NORM_BITS-1:30];
    qt = sq_t[2*NORM_BITS-1:30];
    ratio_eff = (ratio < RATIO_UNITY) ? RATIO_UNITY : ratio;
    slope = $signed({2'b0, RATIO_UNITY}) - $signed({2'b0, ratio_eff});
    d = $signed({1'b0, pe, fe}) - $signed({1'b0, pt, ft});
    f = g_q[23:8];
    mprod = mant * ROOT_TAB[cnt + 5'd1];
    neg = item.main_sample[SAMPLE_BITS-1];
    smag = neg ? SAMPLE_BITS'(-item.main_sample) : item.main_sample;
    n = g_q[GAIN_BITS-1:24];
    sh_full = 16'sd30 - 16'(n);
    sh = sh_full[5:0];
    prod64 = 64'(prod_q);
    if (prod_q == '0) res = '0;
    else if (n >= 15'sd32) res = 64'd1 << 40;
    else if (n < -15'sd32) res = '0;
    else if (n == 15'sd31) res = prod64 << 1;
    else if (n == 15'sd30) res = prod64;
    else res = (prod64 + (64'd1 << (sh - 6'd1))) >> sh;
    limit = (64'd1 << (SAMPLE_BITS - 1)) - (neg ? 64'd0 : 64'd1);
    clip = res > limit;
    if (clip) res = limit;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    write_out = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_next = q_data.duck ? B_LOG : B_DONE;
        end
      end
      B_LOG: if (cnt == 4'd15) state_next = B_GAIN;
      B_GAIN: state_next = B_EXP;
      B_EXP: if (cnt == 4'd15) state_next = B_PROD;
      B_PROD: state_next = B_ROUND;
      B_ROUND: state_next = B_DONE;
      B_DONE: begin
        if (!out_valid || out_ready) begin
          write_out = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        item <= q_data;
        pe <= pe_init;
        pt <= pt_init;
        me <= normalize(env_eff, pe_init);
        mt <= normalize({1'b0, thr_eff}, pt_init);
        fe <= '0;
        ft <= '0;
        cnt <= '0;
        mant <= MANT_ONE;
      end
      B_LOG: begin
        me <= qe[NORM_BITS] ? qe[NORM_BITS:1] : qe[NORM_BITS-1:0];
        mt <= qt[NORM_BITS] ? qt[NORM_BITS:1] : qt[NORM_BITS-1:0];
        fe <= {fe[LOG_FRAC-2:0], qe[NORM_BITS]};
        ft <= {ft[LOG_FRAC-2:0], qt[NORM_BITS]};
        cnt <= cnt + 4'd1;
      end
      B_GAIN: begin
        g_q <= GAIN_BITS'(d * slope);
        cnt <= '0;
      end
      B_EXP: begin
        if (f[4'd15 - cnt]) mant <= mprod[61:30];
        cnt <= cnt + 4'd1;
      end
      B_PROD: prod_q <= smag * mant;
      B_ROUND: begin
        res_q <= neg ? SAMPLE_BITS'(-res) : SAMPLE_BITS'(res);
        clip_q <= clip;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (write_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (write_out) begin
      if (item.duck) begin
        out_data.out_sample <= res_q;
        out_data.ducking <= 1'b1;
        out_data.clipped <= clip_q;
      end else begin
        out_data.out_sample <= item.main_sample;
        out_data.ducking <= 1'b0;
        out_data.clipped <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_clip_needs_duck: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.clipped) |-> out_data.ducking)
    else $error("clipped without ducking");
`endif

endmodule

`default_nettype wire

[sv/sidechain_ducker_top.sv]
// sidechain ducker top level: configuration registers, front end, queue and gain engine
// depends on sdk_pkg, sdk_front, sdk_fifo, sdk_back
//
// in channel (in_valid/in_ready/in_data) carries a main and a sidechain sample per
// transaction; out channel (out_valid/out_ready/out_data) returns one processed sample,
// the ducking flag and the clipped flag for each, in order.
// cfg_we/cfg_index/cfg_data write the threshold, ratio, attack and release
// registers; write only while no transaction is in flight.
// the front end captures a transaction, then does the envelope multiply, the envelope
// sum and the queue push, waiting in the push while the queue is full; it takes no new
// transaction until that push is done, and feeds a 2-entry queue.
// the gain engine takes a passed-through sample straight to its output stage; a ducked
// one goes through 16 log2 squaring steps (envelope and threshold side by side), one
// gain multiply, 16 exp2 root steps, one scale multiply and one round/saturate.
// a stalled receiver holds the output register; the engine and then the queue
// and front end fill and in_ready drops.
// reset clears the envelope to zero and loads the register defaults.
`default_nettype none

module sidechain_ducker_top import sdk_pkg::*; #(
  parameter int QUEUE_DEPTH = SDK_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire in_item_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output out_item_t out_data,
  input  wire logic cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t cfg;
  logic [THR_BITS-1:0] thr_eff;
  q_item_t push_data, head;
  logic push, push_ready, pop, not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr <= THRESHOLD_RESET;
      cfg.ratio <= RATIO_RESET;
      cfg.attack <= ATTACK_RESET;
      cfg.release_c <= RELEASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: cfg.thr <= cfg_data[THR_BITS-1:0];
        REG_RATIO: cfg.ratio <= cfg_data[RATIO_BITS-1:0];
        REG_ATTACK: cfg.attack <= cfg_data[COEF_BITS-1:0];
        REG_RELEASE: cfg.release_c <= cfg_data[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign thr_eff = (cfg.thr == '0) ? THR_BITS'(1) : cfg.thr;

  sdk_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .cfg(cfg), .thr_eff(thr_eff),
    .q_push(push), .q_ready(push_ready), .q_data(push_data)
  );

  sdk_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .push(push), .push_ready(push_ready), .push_data(push_data),
    .pop(pop), .not_empty(not_empty), .head(head)
  );

  sdk_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(not_empty), .q_data(head), .q_pop(pop),
    .thr_eff(thr_eff), .ratio(cfg.ratio),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

`default_nettype wire
